[rtl/ciirld_pkg.sv]
`default_nettype none

package ciirld_pkg;

    localparam int SampleWidthDef = 16;
    localparam int CoefWidthDef   = 16;
    localparam int GuardBits      = 8;

    localparam longint AlphaResetQ16  = 30810;
    localparam int     AlphaResetFrac = 16;

    localparam int CfgIdxWidth     = 2;
    localparam int StageCountWidth = 2;
    localparam int DecimWidth      = 5;
    localparam int PhaseWidth      = 4;

    localparam logic [StageCountWidth-1:0] StageCountRst = 2'd2;
    localparam logic [DecimWidth-1:0]      DecimRst      = 5'd4;
    localparam logic [DecimWidth-1:0]      DecimMax      = 5'd16;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_ALPHA,
        REG_STAGE_COUNT,
        REG_DECIMATION
    } t_reg;

    localparam int StepWidth = 4;

    typedef enum logic [StepWidth-1:0] {
        UC_IDLE,
        UC_S1_FF,
        UC_S1_FB,
        UC_S1_SUM,
        UC_S1_SAT,
        UC_S2_FF,
        UC_S2_FB,
        UC_S2_SUM,
        UC_S2_SAT,
        UC_OUT
    } t_step;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_S1_FF,
        MUL_S1_FB,
        MUL_S2_FF,
        MUL_S2_FB
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT,
        JMP_START
    } t_jmp;

    typedef struct packed {
        logic     take;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     wr_y1;
        logic     commit;
        logic     emit;
        t_jmp     jmp;
    } t_ctl;

    function automatic t_ctl ucode(input t_step step);
        t_ctl w;
        w.take    = 1'b0;
        w.mul_sel = MUL_NONE;
        w.acc_op  = ACC_HOLD;
        w.wr_y1   = 1'b0;
        w.commit  = 1'b0;
        w.emit    = 1'b0;
        w.jmp     = JMP_NEXT;
        case (step)
            UC_IDLE: begin
                w.take = 1'b1;
                w.jmp  = JMP_WAIT_IN;
            end
            UC_S1_FF: begin
                w.mul_sel = MUL_S1_FF;
            end
            UC_S1_FB: begin
                w.mul_sel = MUL_S1_FB;
                w.acc_op  = ACC_LOAD;
            end
            UC_S1_SUM: begin
                w.acc_op = ACC_ADD;
            end
            UC_S1_SAT: begin
                w.wr_y1 = 1'b1;
            end
            UC_S2_FF: begin
                w.mul_sel = MUL_S2_FF;
            end
            UC_S2_FB: begin
                w.mul_sel = MUL_S2_FB;
                w.acc_op  = ACC_LOAD;
            end
            UC_S2_SUM: begin
                w.acc_op = ACC_ADD;
            end
            UC_S2_SAT: begin
                w.commit = 1'b1;
            end
            UC_OUT: begin
                w.emit = 1'b1;
                w.jmp  = JMP_WAIT_OUT;
            end
            default: begin
                w.jmp = JMP_START;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/cascaded_iir_lowpass_decimator.sv]
// Cascaded first-order IIR low-pass with decimation. Each accepted sample
// runs through a ten-step microcode program that drives one shared signed
// multiplier: two products and one saturation per section, for section one
// and then section two, and one output step. The next sample is taken only
// after the program has returned to idle, and an output step that yields a
// word holds while an earlier word is still stalled in the output register.
// The second section updates its history in every mode; stage_count bit 1
// selects which section feeds the output. Every decimation-th sample,
// starting with the first after reset, yields one output word; a decimation
// of zero acts as one and values above 16 act as 16.
`default_nettype none

module cascaded_iir_lowpass_decimator #(
    parameter int SAMPLE_WIDTH = ciirld_pkg::SampleWidthDef,
    parameter int COEF_WIDTH   = ciirld_pkg::CoefWidthDef
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]            o_filtered,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ciirld_pkg::CfgIdxWidth-1:0]   i_cfg_idx,
    input  wire logic [COEF_WIDTH-1:0]                i_cfg_data
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int C  = COEF_WIDTH;
    localparam int SW = W + ciirld_pkg::GuardBits;
    localparam int DW = SW + 1;
    localparam int KW = C + 2;
    localparam int PW = DW + KW;
    localparam int AW = PW + 1;
    localparam int SH = C + 1;
    localparam int SCW = ciirld_pkg::StageCountWidth;
    localparam int DCW = ciirld_pkg::DecimWidth;
    localparam int PHW = ciirld_pkg::PhaseWidth;

    localparam logic [C-1:0] AlphaRst =
        C'((ciirld_pkg::AlphaResetQ16 << C) >> ciirld_pkg::AlphaResetFrac);
    localparam logic signed [AW-1:0] AccRound = {{(AW-C-1){1'b0}}, 1'b1, {C{1'b0}}};
    localparam logic signed [AW-1:0] StMax    = AW'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [SW:0]   OutMax   = (SW+1)'({1'b0, {(W-1){1'b1}}});

    function automatic logic signed [SW-1:0] sat_state(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] q;
        logic signed [SW-1:0] r;
        q = v >>> SH;
        if (q > StMax) begin
            r = {1'b0, {(SW-1){1'b1}}};
        end else if (q < ~StMax) begin
            r = {1'b1, {(SW-1){1'b0}}};
        end else begin
            r = q[SW-1:0];
        end
        return r;
    endfunction

    logic [C-1:0]                 r_alpha;
    logic [SCW-1:0]               r_stages;
    logic [DCW-1:0]               r_decim;
    ciirld_pkg::t_step            r_step;
    ciirld_pkg::t_step            n_step;
    logic [PHW-1:0]               r_phase;
    logic [PHW-1:0]               n_phase;
    logic                         r_emit;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic signed [W-1:0]          r_out;
    logic signed [W-1:0]          r_x;
    logic signed [W-1:0]          r_s1pi;
    logic signed [SW-1:0]         r_s1po;
    logic signed [SW-1:0]         r_s2pi;
    logic signed [SW-1:0]         r_s2po;
    logic signed [SW-1:0]         r_y1;
    logic signed [PW-1:0]         r_prod;
    logic signed [AW-1:0]         r_acc;

    ciirld_pkg::t_ctl             ctl;
    logic                         accept_in;
    logic                         out_busy;
    logic                         out_load;
    logic [C:0]                   coef_ff;
    logic [C:0]                   coef_fb;
    logic signed [DW-1:0]         s1_ff;
    logic signed [DW-1:0]         s2_ff;
    logic signed [DW-1:0]         op_d;
    logic signed [KW-1:0]         op_k;
    logic signed [SW-1:0]         y_sel;
    logic signed [SW:0]           y_rnd;
    logic signed [SW:0]           y_half;
    logic signed [W-1:0]          f_sat;
    logic [DCW-1:0]               d_eff;
    logic [DCW-1:0]               ph_inc;

    assign ctl       = ciirld_pkg::ucode(r_step);
    assign o_stall   = !ctl.take;
    assign accept_in = i_valid && ctl.take;
    assign out_busy  = r_out_valid && i_stall;
    assign out_load  = ctl.emit && r_emit && !out_busy;
    assign o_valid    = r_out_valid;
    assign o_filtered = r_out;

    assign coef_ff = {1'b1, {C{1'b0}}} - {1'b0, r_alpha};
    assign coef_fb = {r_alpha, 1'b0};
    assign s1_ff   = (DW'(r_x) + DW'(r_s1pi)) <<< 1;
    assign s2_ff   = DW'(r_y1) + DW'(r_s2pi);

    always_comb begin
        case (ctl.mul_sel)
            ciirld_pkg::MUL_S1_FF: begin
                op_d = s1_ff;
                op_k = $signed({1'b0, coef_ff});
            end
            ciirld_pkg::MUL_S1_FB: begin
                op_d = DW'(r_s1po);
                op_k = $signed({1'b0, coef_fb});
            end
            ciirld_pkg::MUL_S2_FF: begin
                op_d = s2_ff;
                op_k = $signed({1'b0, coef_ff});
            end
            ciirld_pkg::MUL_S2_FB: begin
                op_d = DW'(r_s2po);
                op_k = $signed({1'b0, coef_fb});
            end
            default: begin
                op_d = '0;
                op_k = '0;
            end
        endcase
    end

    always_comb begin
        y_sel  = r_stages[1] ? r_s2po : r_s1po;
        y_rnd  = (SW+1)'(y_sel) + (SW+1)'(1);
        y_half = y_rnd >>> 1;
        if (y_half > OutMax) begin
            f_sat = {1'b0, {(W-1){1'b1}}};
        end else if (y_half < ~OutMax) begin
            f_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            f_sat = y_half[W-1:0];
        end
    end

    always_comb begin
        if (r_decim == '0) begin
            d_eff = DCW'(1);
        end else if (r_decim > ciirld_pkg::DecimMax) begin
            d_eff = ciirld_pkg::DecimMax;
        end else begin
            d_eff = r_decim;
        end
        ph_inc  = {1'b0, r_phase} + DCW'(1);
        n_phase = (ph_inc >= d_eff) ? '0 : ph_inc[PHW-1:0];
    end

    always_comb begin
        case (ctl.jmp)
            ciirld_pkg::JMP_NEXT: begin
                n_step = ciirld_pkg::t_step'(r_step + 1'b1);
            end
            ciirld_pkg::JMP_WAIT_IN: begin
                n_step = accept_in ? ciirld_pkg::t_step'(r_step + 1'b1) : r_step;
            end
            ciirld_pkg::JMP_WAIT_OUT: begin
                n_step = (r_emit && out_busy) ? r_step : ciirld_pkg::UC_IDLE;
            end
            default: begin
                n_step = ciirld_pkg::UC_IDLE;
            end
        endcase
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= AlphaRst;
            r_stages    <= ciirld_pkg::StageCountRst;
            r_decim     <= ciirld_pkg::DecimRst;
            r_step      <= ciirld_pkg::UC_IDLE;
            r_phase     <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            r_s1pi      <= '0;
            r_s1po      <= '0;
            r_s2pi      <= '0;
            r_s2po      <= '0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ciirld_pkg::REG_ALPHA: begin
                        r_alpha <= i_cfg_data;
                    end
                    ciirld_pkg::REG_STAGE_COUNT: begin
                        r_stages <= i_cfg_data[SCW-1:0];
                    end
                    ciirld_pkg::REG_DECIMATION: begin
                        r_decim <= i_cfg_data[DCW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (ctl.commit) begin
                r_s1pi  <= r_x;
                r_s1po  <= r_y1;
                r_s2pi  <= r_y1;
                r_s2po  <= sat_state(r_acc);
                r_emit  <= (r_phase == '0);
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_x <= i_sample;
        end
        r_prod <= PW'(op_d) * PW'(op_k);
        case (ctl.acc_op)
            ciirld_pkg::ACC_LOAD: begin
                r_acc <= AW'(r_prod) + AccRound;
            end
            ciirld_pkg::ACC_ADD: begin
                r_acc <= r_acc + AW'(r_prod);
            end
            default: begin
            end
        endcase
        if (ctl.wr_y1) begin
            r_y1 <= sat_state(r_acc);
        end
        if (out_load) begin
            r_out <= f_sat;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |=> (r_step == ciirld_pkg::UC_S1_FF))
        else $error("accepted word did not start the section program");

    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(out_load))
        else $error("output word appeared outside the output step");

    a_hold_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.emit && r_emit && out_busy) |=> (r_step == $past(r_step)) && $stable(r_s2po))
        else $error("output step advanced while output register was held");

    a_load_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_step == ciirld_pkg::UC_IDLE) && o_valid)
        else $error("output load did not return to idle with a valid word");

endmodule

`default_nettype wire
